// File: sv/assert_macros.svh
// Assertion macros used by the rank-one update controller.
// Each macro expects the signals clk and arst_n in the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every rising edge outside reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// The expression must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// File: sv/r1opu_pkg.sv
// Package for the rank-one outer-product update core.
// Holds function codes, register indexes, widths and controller/datapath structs.
`default_nettype none

package r1opu_pkg;

	localparam int unsigned MAX_ROWS_DEF = 16;
	localparam int unsigned MAX_COLS_DEF = 16;

	localparam int FUNC_W  = 3;
	localparam int IDX_W   = 4;
	localparam int VEC_W   = 16;
	localparam int MAT_W   = 32;
	localparam int CFG_W   = 5;
	localparam int CFG_IDX_W = 1;
	// Width for comparing counts against the parameters (up to 1023) and registers.
	localparam int CNT_W   = 10;

	localparam logic [FUNC_W-1:0] FN_WR_MAT = 3'd0;
	localparam logic [FUNC_W-1:0] FN_LD_X   = 3'd1;
	localparam logic [FUNC_W-1:0] FN_LD_Y   = 3'd2;
	localparam logic [FUNC_W-1:0] FN_UPDATE = 3'd3;
	localparam logic [FUNC_W-1:0] FN_READ   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	localparam logic signed [MAT_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [MAT_W-1:0] Q_MIN = 32'sh8000_0000;

	typedef struct packed {
		logic wr_mat;
		logic wr_x;
		logic wr_y;
		logic walk_start;
		logic walk_issue;
		logic rd_issue;
		logic out_load_rd;
		logic out_load_upd;
	} r1opu_cmd_t;

	typedef struct packed {
		logic walk_last;
		logic walk_empty;
		logic pipe_busy;
	} r1opu_sts_t;

endpackage

`default_nettype wire

// File: sv/r1opu_ctrl.sv
// Controller state machine of the rank-one update core.
// Depends on r1opu_pkg for command/status structs and function codes.
`default_nettype none

`include "assert_macros.svh"

module r1opu_ctrl
	import r1opu_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [FUNC_W-1:0] func,
	output logic                   out_valid,
	input  wire logic              out_ready,
	input  wire r1opu_sts_t        sts,
	output r1opu_cmd_t             cmd
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_READ  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;
	logic       accept;
	logic [5:0] mem_cmds;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign mem_cmds  = {cmd.wr_mat, cmd.wr_x, cmd.wr_y, cmd.walk_start, cmd.walk_issue,
		cmd.rd_issue};

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (func)
						FN_WR_MAT: cmd.wr_mat = 1'b1;
						FN_LD_X:   cmd.wr_x = 1'b1;
						FN_LD_Y:   cmd.wr_y = 1'b1;
						FN_UPDATE: begin
							cmd.walk_start = 1'b1;
							state_d = sts.walk_empty ? ST_DRAIN : ST_WALK;
						end
						FN_READ: begin
							cmd.rd_issue = 1'b1;
							state_d = ST_READ;
						end
						default: ;
					endcase
				end
			end
			ST_WALK: begin
				cmd.walk_issue = 1'b1;
				if (sts.walk_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy && out_free) begin
					cmd.out_load_upd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (out_free) begin
					cmd.out_load_rd = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load_rd || cmd.out_load_upd) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The update pipeline must be empty whenever a new item can be taken.
	`ASSERT_ALWAYS(a_idle_drained, in_ready |-> !sts.pipe_busy, "item taken with update in flight")
	// Memory and walk commands are mutually exclusive.
	`ASSERT_ALWAYS(a_cmd_excl, $onehot0(mem_cmds), "conflicting datapath commands")
	// A read result is only waited for after a read was issued.
	`ASSERT_ALWAYS(a_read_origin, (state_q == ST_READ) |-> ($past(cmd.rd_issue) || $past(state_q == ST_READ)), "read state without a read")

endmodule

`default_nettype wire

// File: sv/r1opu_dp.sv
// Datapath of the rank-one update core: stores, walk counters, MAC pipeline, result register.
// Depends on r1opu_pkg; driven by r1opu_ctrl through command and status structs.
`default_nettype none

module r1opu_dp
	import r1opu_pkg::*;
#(
	parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_wdata,
	input  wire logic [IDX_W-1:0]        row,
	input  wire logic [IDX_W-1:0]        col,
	input  wire logic signed [VEC_W-1:0] vec_value,
	input  wire logic signed [MAT_W-1:0] mat_value,
	input  wire r1opu_cmd_t              cmd,
	output r1opu_sts_t                   sts,
	output logic signed [MAT_W-1:0]      read_value,
	output logic                         update_done,
	output logic                         saturated
);

	localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam logic [CNT_W-1:0] MAXR_E = CNT_W'(MAX_ROWS);
	localparam logic [CNT_W-1:0] MAXC_E = CNT_W'(MAX_COLS);

	logic signed [MAT_W-1:0] mat_mem [DEPTH];
	logic signed [VEC_W-1:0] x_mem   [MAX_ROWS];
	logic signed [VEC_W-1:0] y_mem   [MAX_COLS];

	logic [CFG_W-1:0] rows_q, cols_q;
	logic [CNT_W-1:0] rows_e, cols_e, nr, nc;
	logic             rok, cok;
	logic [AW-1:0]    item_addr;

	logic [RIW-1:0] r_q;
	logic [CIW-1:0] c_q;
	logic [AW-1:0]  base_q;
	logic [AW-1:0]  walk_addr;
	logic           r_last, c_last;

	logic                    rd_en;
	logic [AW-1:0]           rd_addr;
	logic signed [MAT_W-1:0] m_rdata_q;
	logic signed [VEC_W-1:0] x_rdata_q, y_rdata_q;
	logic                    rd_zero_q;

	logic          v_s1, v_s2;
	logic [AW-1:0] addr_s1, addr_s2;
	logic signed [MAT_W-1:0] prod_s2, m_s2;
	logic signed [MAT_W:0]   sum;
	logic signed [MAT_W-1:0] sum_sat;
	logic                    clip;
	logic                    sat_q;

	logic                    wr_en;
	logic [AW-1:0]           wr_addr;
	logic signed [MAT_W-1:0] wr_data;

	logic signed [MAT_W-1:0] read_value_q;
	logic                    update_done_q, saturated_q;

	// Configuration registers; counts above the parameters clamp to them.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CFG_RESET;
			cols_q <= CFG_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ROWS: rows_q <= cfg_wdata;
				REG_COLS: cols_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign rows_e = CNT_W'(rows_q);
	assign cols_e = CNT_W'(cols_q);
	assign nr     = (rows_e > MAXR_E) ? MAXR_E : rows_e;
	assign nc     = (cols_e > MAXC_E) ? MAXC_E : cols_e;

	assign rok       = CNT_W'(row) < MAXR_E;
	assign cok       = CNT_W'(col) < MAXC_E;
	assign item_addr = AW'(int'(row) * int'(MAX_COLS) + int'(col));

	// Walk counters: row, column and the row base address.
	assign c_last    = (CNT_W'(c_q) + CNT_W'(1)) == nc;
	assign r_last    = (CNT_W'(r_q) + CNT_W'(1)) == nr;
	assign walk_addr = base_q + AW'(c_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q    <= '0;
			c_q    <= '0;
			base_q <= '0;
		end else if (cmd.walk_start) begin
			r_q    <= '0;
			c_q    <= '0;
			base_q <= '0;
		end else if (cmd.walk_issue) begin
			if (c_last) begin
				c_q    <= '0;
				r_q    <= r_q + RIW'(1);
				base_q <= AW'(int'(base_q) + int'(MAX_COLS));
			end else begin
				c_q <= c_q + CIW'(1);
			end
		end
	end

	assign sts.walk_last  = r_last && c_last;
	assign sts.walk_empty = (nr == '0) || (nc == '0);
	assign sts.pipe_busy  = v_s1 || v_s2;

	// Memory read port, shared by the walk and by read items.
	assign rd_en   = cmd.walk_issue || cmd.rd_issue;
	assign rd_addr = cmd.walk_issue ? walk_addr : item_addr;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			m_rdata_q <= mat_mem[rd_addr];
		end
		if (cmd.walk_issue) begin
			x_rdata_q <= x_mem[r_q];
			y_rdata_q <= y_mem[c_q];
		end
		if (cmd.rd_issue) begin
			rd_zero_q <= !(rok && cok);
		end
	end

	// Stage 1 holds read data; stage 2 holds the product; the sum is written back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.walk_issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= walk_addr;
		addr_s2 <= addr_s1;
		prod_s2 <= MAT_W'(x_rdata_q) * MAT_W'(y_rdata_q);
		m_s2    <= m_rdata_q;
	end

	assign sum  = $signed({m_s2[MAT_W-1], m_s2}) + $signed({prod_s2[MAT_W-1], prod_s2});
	assign clip = sum[MAT_W] != sum[MAT_W-1];
	assign sum_sat = !clip ? sum[MAT_W-1:0] : (sum[MAT_W] ? Q_MIN : Q_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.walk_start) begin
			sat_q <= 1'b0;
		end else if (v_s2 && clip) begin
			sat_q <= 1'b1;
		end
	end

	// Memory write port: update write-back or a matrix word item.
	assign wr_en   = v_s2 || (cmd.wr_mat && rok && cok);
	assign wr_addr = v_s2 ? addr_s2 : item_addr;
	assign wr_data = v_s2 ? sum_sat : mat_value;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mat_mem[wr_addr] <= wr_data;
		end
		if (cmd.wr_x && rok) begin
			x_mem[RIW'(row)] <= vec_value;
		end
		if (cmd.wr_y && cok) begin
			y_mem[CIW'(col)] <= vec_value;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.out_load_rd) begin
			read_value_q  <= rd_zero_q ? '0 : m_rdata_q;
			update_done_q <= 1'b0;
			saturated_q   <= 1'b0;
		end else if (cmd.out_load_upd) begin
			read_value_q  <= '0;
			update_done_q <= 1'b1;
			saturated_q   <= sat_q;
		end
	end

	assign read_value  = read_value_q;
	assign update_done = update_done_q;
	assign saturated   = saturated_q;

endmodule

`default_nettype wire

// File: sv/rank_one_outer_product_update_core.sv
// Top level of the rank-one outer-product update core (M := M + x * y^T).
// Depends on r1opu_pkg, r1opu_ctrl and r1opu_dp.
`default_nettype none

// This core keeps a MAX_ROWS by MAX_COLS matrix of signed Q16.16 words and two
// vectors x and y of signed Q8.8 elements, and applies the rank-one update
// M := M + x * y^T over the rows and columns in use, as used for Hebbian weight
// learning. Each input transfer carries a function code: write a matrix word,
// load an x or y element, run the update, or read a matrix word back. Writes and
// loads produce no result. A read result passes from the memory read register
// into the output register, and the next item can be accepted in the cycle in
// which that result is presented. An update result is presented once the walk
// and the drain are done, and the input stays closed until then: the controller
// walks the entries in use one per cycle through a three-stage read, multiply,
// add-and-saturate pipeline on the matrix memory, which has one read and one
// write port, then waits for the pipeline to drain before the result transfer.
// A read or update whose result is ready waits further while the previous result
// has not been taken. Each accumulation saturates to the signed 32-bit range;
// the update result reports whether any entry clipped and carries a read_value
// of zero. The core takes one item at a time, but a finished result sits in an
// output register, so the next item is accepted while that result waits to be
// taken. Configuration (row and column counts, clamped to the parameters, zero
// meaning an empty update) must be written only while the core is idle, which
// the core does not enforce. The stores are not cleared at reset; every entry
// an update or read touches must have been written first.

module rank_one_outer_product_update_core
	import r1opu_pkg::*;
#(
	parameter int unsigned MAX_ROWS = MAX_ROWS_DEF,
	parameter int unsigned MAX_COLS = MAX_COLS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// Configuration write port.
	input  wire logic                    cfg_we,
	input  wire logic [CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [CFG_W-1:0]        cfg_wdata,
	// Input channel.
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [FUNC_W-1:0]       func,
	input  wire logic [IDX_W-1:0]        row,
	input  wire logic [IDX_W-1:0]        col,
	input  wire logic signed [VEC_W-1:0] vec_value,
	input  wire logic signed [MAT_W-1:0] mat_value,
	// Result channel.
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic signed [MAT_W-1:0]      read_value,
	output logic                         update_done,
	output logic                         saturated
);

	r1opu_cmd_t cmd;
	r1opu_sts_t sts;

	// The controller sequences each item and owns the result valid flag.
	r1opu_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// The datapath holds the stores, the walk counters, the multiply-accumulate
	// pipeline and the result payload register.
	r1opu_dp #(
		.MAX_ROWS (MAX_ROWS),
		.MAX_COLS (MAX_COLS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.row         (row),
		.col         (col),
		.vec_value   (vec_value),
		.mat_value   (mat_value),
		.cmd         (cmd),
		.sts         (sts),
		.read_value  (read_value),
		.update_done (update_done),
		.saturated   (saturated)
	);

endmodule

`default_nettype wire

// File: tb/rank_one_outer_product_update_core_tb.sv
// Self-checking testbench for the rank-one outer-product update core (M := M + x * y^T).
// Uses r1opu_pkg for widths, function codes and register indexes; needs only the RTL.
// A behavioral predictor tracks the matrix and vectors and checks every result in order.
`default_nettype none

module rank_one_outer_product_update_core_tb
	import r1opu_pkg::*;
();
	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no transfer on either channel before the run is declared hung.
	// A full 16 by 16 update keeps the input side closed for its whole walk and drain.
	localparam int WATCHDOG_LIMIT = 4000;
	// Cycles allowed after the last result for a trailing write or load to land.
	localparam int SETTLE_CYCLES  = 8;
	localparam int ITEMS_PER_PHASE = 85;

	// One expected result transfer.
	typedef struct packed {
		logic signed [MAT_W-1:0] value;
		logic                    done;
		logic                    sat;
	} ger_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic [IDX_W-1:0] row = '0;
	logic [IDX_W-1:0] col = '0;
	logic signed [VEC_W-1:0] vec_value = '0;
	logic signed [MAT_W-1:0] mat_value = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [MAT_W-1:0] read_value;
	logic update_done;
	logic saturated;

	// Predictor state: the matrix and both vectors as the core should hold them,
	// plus the two shape registers as last written.
	logic signed [MAT_W-1:0] matrix_image [MAX_ROWS_DEF*MAX_COLS_DEF];
	logic signed [VEC_W-1:0] x_image [MAX_ROWS_DEF];
	logic signed [VEC_W-1:0] y_image [MAX_COLS_DEF];
	logic [CFG_W-1:0] rows_setting = CFG_RESET;
	logic [CFG_W-1:0] cols_setting = CFG_RESET;

	// Results the core still owes, oldest first.
	ger_result_t pending_results [$];

	int error_count = 0;
	int quiet_cycles = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;

	rank_one_outer_product_update_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.row        (row),
		.col        (col),
		.vec_value  (vec_value),
		.mat_value  (mat_value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.read_value (read_value),
		.update_done(update_done),
		.saturated  (saturated)
	);

	always #5 clk = ~clk;

	// The shape registers clamp to the store size; zero gives an empty update.
	function automatic int eff_rows();
		return (rows_setting > MAX_ROWS_DEF) ? MAX_ROWS_DEF : int'(rows_setting);
	endfunction

	function automatic int eff_cols();
		return (cols_setting > MAX_COLS_DEF) ? MAX_COLS_DEF : int'(cols_setting);
	endfunction

	// Vector elements lean toward the extremes so that updates clip in both directions.
	function automatic logic signed [VEC_W-1:0] pick_vec();
		case ($urandom_range(4))
			0: begin
				return 16'sh7FFF;
			end
			1: begin
				return 16'sh8000;
			end
			2: begin
				return VEC_W'(int'($urandom_range(1023)) - 512);
			end
			default: begin
				return VEC_W'($urandom());
			end
		endcase
	endfunction

	function automatic logic signed [MAT_W-1:0] pick_mat();
		case ($urandom_range(4))
			0: begin
				return Q_MAX;
			end
			1: begin
				return Q_MIN;
			end
			2: begin
				return MAT_W'(int'($urandom_range(2097151)) - 1048576);
			end
			default: begin
				return MAT_W'($urandom());
			end
		endcase
	endfunction

	// Predictor: applies one accepted item to the image of the stores and queues
	// the result it should produce, if any.
	task automatic apply_item(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [VEC_W-1:0] v,
			input logic signed [MAT_W-1:0] m);
		int nr;
		int nc;
		int addr;
		longint acc;
		logic clipped;
		ger_result_t res;
		addr = int'(r) * MAX_COLS_DEF + int'(c);
		case (f)
			FN_WR_MAT: begin
				matrix_image[addr] = m;
			end
			FN_LD_X: begin
				x_image[r] = v;
			end
			FN_LD_Y: begin
				y_image[c] = v;
			end
			FN_UPDATE: begin
				nr = eff_rows();
				nc = eff_cols();
				clipped = 1'b0;
				for (int i = 0; i < nr; i++) begin
					for (int j = 0; j < nc; j++) begin
						acc = longint'(matrix_image[i*MAX_COLS_DEF + j]) +
							longint'(x_image[i]) * longint'(y_image[j]);
						if (acc > longint'(Q_MAX)) begin
							acc = longint'(Q_MAX);
							clipped = 1'b1;
						end else if (acc < longint'(Q_MIN)) begin
							acc = longint'(Q_MIN);
							clipped = 1'b1;
						end
						matrix_image[i*MAX_COLS_DEF + j] = acc[MAT_W-1:0];
					end
				end
				res.value = '0;
				res.done = 1'b1;
				res.sat = clipped;
				pending_results.push_back(res);
			end
			FN_READ: begin
				res.value = matrix_image[addr];
				res.done = 1'b0;
				res.sat = 1'b0;
				pending_results.push_back(res);
			end
			default: begin
			end
		endcase
	endtask

	task automatic report_mismatch(input string msg);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, msg);
	endtask

	// Presents one item and holds it until the transfer happens. The valid line
	// is left high after the transfer; the next call either replaces the payload
	// or drops valid at the following falling edge, so no item is taken twice.
	task automatic send_item(input logic [FUNC_W-1:0] f, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic signed [VEC_W-1:0] v,
			input logic signed [MAT_W-1:0] m);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		row <= r;
		col <= c;
		vec_value <= v;
		mat_value <= m;
		@(posedge clk);
		while (!in_ready) begin
			@(posedge clk);
		end
		apply_item(f, r, c, v, m);
	endtask

	// Stops sending and waits until every owed result has been taken, then lets
	// a trailing write or load finish. This is also the sender's long pause.
	task automatic drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(negedge clk);
		end
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Register writes happen only with the core idle.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ROWS) begin
			rows_setting = value;
		end else begin
			cols_setting = value;
		end
	endtask

	task automatic set_shape(input logic [CFG_W-1:0] rows_value, input logic [CFG_W-1:0] cols_value);
		write_register(REG_ROWS, rows_value);
		write_register(REG_COLS, cols_value);
	endtask

	task automatic set_idling(input int idle_pct, input int stall_pct);
		sender_idle_pct = idle_pct;
		receiver_stall_pct = stall_pct;
	endtask

	// Every matrix word and vector element is written once up front, so that no
	// later read or update can touch an entry that was never written.
	task automatic test_fill_stores();
		for (int i = 0; i < MAX_ROWS_DEF; i++) begin
			for (int j = 0; j < MAX_COLS_DEF; j++) begin
				send_item(FN_WR_MAT, IDX_W'(i), IDX_W'(j), VEC_W'($urandom()), pick_mat());
			end
		end
		for (int i = 0; i < MAX_ROWS_DEF; i++) begin
			send_item(FN_LD_X, IDX_W'(i), IDX_W'($urandom()), pick_vec(), MAT_W'($urandom()));
		end
		for (int j = 0; j < MAX_COLS_DEF; j++) begin
			send_item(FN_LD_Y, IDX_W'($urandom()), IDX_W'(j), pick_vec(), MAT_W'($urandom()));
		end
	endtask

	// Directed corners: clipping at both rails, an exact product with no
	// clipping, an empty update, the unused function codes, and a full-size
	// update with the shape registers above their range.
	task automatic test_directed_corners();
		send_item(FN_WR_MAT, 4'd0, 4'd0, 16'sh0, Q_MAX);
		send_item(FN_LD_X, 4'd0, 4'd0, 16'sh7FFF, '0);
		send_item(FN_LD_Y, 4'd0, 4'd0, 16'sh7FFF, '0);
		set_shape(5'd1, 5'd1);
		send_item(FN_UPDATE, 4'd0, 4'd0, 16'sh0, '0);
		send_item(FN_READ, 4'd0, 4'd0, 16'sh0, '0);

		send_item(FN_WR_MAT, 4'd0, 4'd0, 16'sh0, Q_MIN);
		send_item(FN_LD_Y, 4'd0, 4'd0, 16'sh8000, '0);
		send_item(FN_UPDATE, 4'hF, 4'hF, 16'shFFFF, '1);
		send_item(FN_READ, 4'd0, 4'd0, 16'sh0, '0);

		send_item(FN_WR_MAT, 4'd0, 4'd0, 16'sh0, '0);
		send_item(FN_LD_X, 4'd0, 4'd0, 16'sh0180, '0);
		send_item(FN_LD_Y, 4'd0, 4'd0, 16'shFF00, '0);
		send_item(FN_UPDATE, 4'd0, 4'd0, 16'sh0, '0);
		send_item(FN_READ, 4'd0, 4'd0, 16'sh0, '0);

		// Zero rows: the update still answers, touching nothing.
		set_shape(5'd0, 5'd1);
		send_item(FN_UPDATE, 4'd0, 4'd0, 16'sh0, '0);
		send_item(FN_READ, 4'd0, 4'd0, 16'sh0, '0);

		// Unused function codes must be swallowed without a result.
		send_item(3'd5, 4'hF, 4'h0, 16'sh7FFF, Q_MAX);
		send_item(3'd6, 4'h0, 4'hF, 16'sh8000, Q_MIN);
		send_item(3'd7, 4'hA, 4'h5, 16'sh5555, 32'shAAAA_5555);

		set_shape(5'd31, 5'd31);
		send_item(FN_LD_X, 4'hF, 4'h0, 16'sh8000, '0);
		send_item(FN_LD_Y, 4'h0, 4'hF, 16'sh8000, '0);
		send_item(FN_WR_MAT, 4'hF, 4'hF, 16'sh0, '0);
		send_item(FN_UPDATE, 4'd0, 4'd0, 16'sh0, '0);
		send_item(FN_READ, 4'hF, 4'hF, 16'sh0, '0);
		send_item(FN_READ, 4'h0, 4'hF, 16'sh0, '0);
	endtask

	// One learning step as software would issue it: load some vector elements
	// inside the active shape, maybe patch a weight, run the update, read back.
	task automatic learning_step(output int items);
		int nr;
		int nc;
		int loads;
		int reads;
		nr = eff_rows();
		nc = eff_cols();
		items = 0;
		loads = $urandom_range(6);
		repeat (loads) begin
			if ($urandom_range(1) != 0) begin
				send_item(FN_LD_X, IDX_W'($urandom_range((nr > 0) ? nr - 1 : 0)),
					IDX_W'($urandom()), pick_vec(), MAT_W'($urandom()));
			end else begin
				send_item(FN_LD_Y, IDX_W'($urandom()),
					IDX_W'($urandom_range((nc > 0) ? nc - 1 : 0)), pick_vec(),
					MAT_W'($urandom()));
			end
			items++;
		end
		if ($urandom_range(3) == 0) begin
			send_item(FN_WR_MAT, IDX_W'($urandom_range((nr > 0) ? nr - 1 : 0)),
				IDX_W'($urandom_range((nc > 0) ? nc - 1 : 0)), VEC_W'($urandom()),
				pick_mat());
			items++;
		end
		send_item(FN_UPDATE, IDX_W'($urandom()), IDX_W'($urandom()), VEC_W'($urandom()),
			MAT_W'($urandom()));
		items++;
		reads = $urandom_range(1, 4);
		repeat (reads) begin
			if (nr > 0 && nc > 0 && $urandom_range(3) != 0) begin
				send_item(FN_READ, IDX_W'($urandom_range(nr - 1)), IDX_W'($urandom_range(nc - 1)),
					VEC_W'($urandom()), MAT_W'($urandom()));
			end else begin
				send_item(FN_READ, IDX_W'($urandom()), IDX_W'($urandom()), VEC_W'($urandom()),
					MAT_W'($urandom()));
			end
			items++;
		end
	endtask

	// A single item with every field random, unused function codes included.
	// Returns how many items the core actually acts on.
	task automatic noise_item(output int items);
		logic [FUNC_W-1:0] f;
		f = FUNC_W'($urandom());
		send_item(f, IDX_W'($urandom()), IDX_W'($urandom()), pick_vec(), pick_mat());
		items = (f <= FN_READ) ? 1 : 0;
	endtask

	// Random traffic over several shapes and idling patterns. Each phase change
	// drains the core first, which also exercises the sender waiting it out.
	task automatic test_random_phases();
		int done;
		int n;
		for (int p = 0; p < 8; p++) begin
			case (p)
				0: set_shape(5'd1, 5'd1);
				1: set_shape(5'd2, 5'd9);
				2: set_shape(5'd3, 5'd17);
				3: set_shape(5'd31, 5'd2);
				4: set_shape(5'd16, 5'd16);
				5: set_shape(5'd4, 5'd4);
				6: set_shape(5'd7, 5'd0);
				default: set_shape(5'd5, 5'd3);
			endcase
			case (p % 4)
				0: set_idling(0, 0);
				1: set_idling(52, 0);
				2: set_idling(0, 52);
				default: set_idling(19, 19);
			endcase
			done = 0;
			while (done < ITEMS_PER_PHASE) begin
				if ($urandom_range(9) < 7) begin
					learning_step(n);
				end else begin
					noise_item(n);
				end
				done += n;
			end
		end
	endtask

	// The result side stalls at the chosen rate; a rate of zero keeps ready high.
	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	// Every result transfer is matched against the oldest owed result.
	always @(posedge clk) begin : check_results
		ger_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result transfer with no result owed");
			end else begin
				want = pending_results.pop_front();
				if (read_value !== want.value) begin
					report_mismatch($sformatf("read_value %h, expected %h", read_value, want.value));
				end
				if (update_done !== want.done) begin
					report_mismatch($sformatf("update_done %b, expected %b", update_done, want.done));
				end
				if (saturated !== want.sat) begin
					report_mismatch($sformatf("saturated %b, expected %b", saturated, want.sat));
				end
			end
		end
	end

	// Watchdog: any transfer on either channel counts as progress.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL rank_one_outer_product_update_core");
			$finish;
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_idling(0, 0);
		test_fill_stores();
		test_directed_corners();
		test_random_phases();
		drain_results();
		if (error_count == 0) begin
			$display("PASS rank_one_outer_product_update_core");
		end else begin
			$display("FAIL rank_one_outer_product_update_core");
		end
		$finish;
	end

endmodule

`default_nettype wire
